// File: src/spq_pkg.sv
package spq_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_POP_EMPTY = 2'd1;
   localparam logic [1:0] ST_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic        command;
      logic [7:0]  item_value;
      logic [15:0] priority_req;
   } req_type;

   typedef struct packed {
      logic [7:0]  front_item;
      logic [15:0] front_priority;
      logic        is_empty;
      logic        is_full;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  item;
      logic [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

endpackage

// File: src/spq_cell.sv
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type    new_entry,
   input  logic                  occupied,
   input  logic                  first_free,
   input  logic                  prev_greater,
   input  spq_pkg::entry_type    prev_entry,
   input  spq_pkg::entry_type    next_entry,
   output logic                  greater,
   output spq_pkg::entry_type    entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // stored entry sorts behind the new one
   assign greater = occupied && (entry_ff.prio > new_entry.prio);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (greater || first_free) begin
            if (prev_greater) begin
               entry_in = prev_entry;
            end else begin
               entry_in = new_entry;
            end
         end
      end else if (ctrl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: src/stable_priority_queue.sv
// response: the strobe rises in the cycle after the command is taken
// throughput: one command per cycle; all cells shift or load together,
// so busy stays low
// reset: synchronous, active high; clears the entry count (queue empty) and
// the response strobe; cell contents are not cleared
module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic [1:0]    status_ff;
   logic [1:0]    status_in;

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   entry_type     cell_entry [CAPACITY];
   logic          cell_greater [CAPACITY];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign new_entry = '{item: req_data.item_value, prio: req_data.priority_req};

   always_comb begin
      ctrl      = '0;
      count_in  = count_ff;
      status_in = ST_DONE;
      if (accept) begin
         if (req_data.command == CMD_PUSH) begin
            if (full) begin
               status_in = ST_PUSH_FULL;
            end else begin
               ctrl.push = 1'b1;
               count_in  = count_ff + CW'(1);
            end
         end else begin
            if (empty) begin
               status_in = ST_POP_EMPTY;
            end else begin
               ctrl.pop = 1'b1;
               count_in = count_ff - CW'(1);
            end
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      first_free;
      logic      prev_greater;
      entry_type prev_entry;
      entry_type next_entry;

      assign occupied   = (CW'(i) < count_ff);
      assign first_free = (CW'(i) == count_ff);

      if (i == 0) begin : g_head
         assign prev_greater = 1'b0;
         assign prev_entry   = new_entry;
      end else begin : g_body
         assign prev_greater = cell_greater[i-1];
         assign prev_entry   = cell_entry[i-1];
      end

      // last cell has nothing behind it; its content is dead after a pop
      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (occupied),
         .first_free  (first_free),
         .prev_greater(prev_greater),
         .prev_entry  (prev_entry),
         .next_entry  (next_entry),
         .greater     (cell_greater[i]),
         .entry       (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      status_ff <= status_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_data.front_item     = empty ? 8'd0 : cell_entry[0].item;
   assign rsp_data.front_priority = empty ? 16'd0 : cell_entry[0].prio;
   assign rsp_data.is_empty       = empty;
   assign rsp_data.is_full        = full;
   assign rsp_data.status         = status_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> (count_ff == $past(count_ff) + CW'(1)) && (status_ff == ST_DONE))
      else $error("push did not add one entry");

   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !ctrl.push && !ctrl.pop) |=> $stable(count_ff) && (status_ff != ST_DONE))
      else $error("refused command changed the queue");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
      else $error("front cells out of order");
`endif

endmodule
